[design/dmt_pkg.sv]
package dmt_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int DIST_W   = 16;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 7;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [DIST_W-1:0] DIST_SAT = 16'hFFFF;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 7'd64;

  typedef struct packed {
    logic cmd;
    logic cell_value;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic              last;
  } out_item_t;

  // image geometry as seen by the sequencer, plus a restart strobe
  typedef struct packed {
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;
    logic             restart;
  } geom_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWR,
    ST_BRD,
    ST_BWR,
    ST_FDATA
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    return (v == DIST_SAT) ? DIST_SAT : v + 1'b1;
  endfunction

  function automatic logic [DIST_W-1:0] dmin(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

endpackage

[design/dmt_ram.sv]
module dmt_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [dmt_pkg::ADDR_W-1:0] waddr,
  input  logic [dmt_pkg::DIST_W-1:0] wdata,
  input  logic [dmt_pkg::ADDR_W-1:0] raddr_a,
  output logic [dmt_pkg::DIST_W-1:0] rdata_a,
  input  logic [dmt_pkg::ADDR_W-1:0] raddr_b,
  output logic [dmt_pkg::DIST_W-1:0] rdata_b
);

  logic [dmt_pkg::DIST_W-1:0] mem [dmt_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[design/dmt_cfg.sv]
module dmt_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dmt_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [dmt_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [dmt_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output dmt_pkg::geom_t             geom
);

  logic [dmt_pkg::CFG_W-1:0] row_count_r, row_count_nxt;
  logic [dmt_pkg::CFG_W-1:0] col_count_r, col_count_nxt;
  logic                      wr_en;
  logic                      reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (wr_en) begin
      case (reg_sel)
        dmt_pkg::REG_ROW_COUNT: row_count_nxt = cfg_pwdata[dmt_pkg::CFG_W-1:0];
        dmt_pkg::REG_COL_COUNT: col_count_nxt = cfg_pwdata[dmt_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= dmt_pkg::ROW_COUNT_RST;
      col_count_r <= dmt_pkg::COL_COUNT_RST;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      dmt_pkg::REG_ROW_COUNT:
        cfg_prdata = dmt_pkg::APB_DW'(row_count_r);
      dmt_pkg::REG_COL_COUNT:
        cfg_prdata = dmt_pkg::APB_DW'(col_count_r);
      default: cfg_prdata = '0;
    endcase
  end

  // zero acts as one, anything above the array size acts as the array size
  always_comb begin
    if (row_count_r == '0) begin
      geom.last_row = '0;
    end else if (int'(row_count_r) > dmt_pkg::MAX_ROWS) begin
      geom.last_row = dmt_pkg::ROW_W'(dmt_pkg::MAX_ROWS - 1);
    end else begin
      geom.last_row = dmt_pkg::ROW_W'(row_count_r - 1'b1);
    end
    if (col_count_r == '0) begin
      geom.last_col = '0;
    end else if (int'(col_count_r) > dmt_pkg::MAX_COLS) begin
      geom.last_col = dmt_pkg::COL_W'(dmt_pkg::MAX_COLS - 1);
    end else begin
      geom.last_col = dmt_pkg::COL_W'(col_count_r - 1'b1);
    end
    geom.restart = wr_en;
  end

endmodule

[design/dmt_ctrl.sv]
module dmt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dmt_pkg::geom_t             geom,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dmt_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dmt_pkg::out_item_t         out_data,
  output logic                       mem_we,
  output logic [dmt_pkg::ADDR_W-1:0] mem_waddr,
  output logic [dmt_pkg::DIST_W-1:0] mem_wdata,
  output logic [dmt_pkg::ADDR_W-1:0] mem_raddr_a,
  input  logic [dmt_pkg::DIST_W-1:0] mem_rdata_a,
  output logic [dmt_pkg::ADDR_W-1:0] mem_raddr_b,
  input  logic [dmt_pkg::DIST_W-1:0] mem_rdata_b
);

  dmt_pkg::state_t state_r, state_nxt;

  logic [dmt_pkg::ROW_W-1:0]  ld_row_r, ld_row_nxt;
  logic [dmt_pkg::COL_W-1:0]  ld_col_r, ld_col_nxt;
  logic [dmt_pkg::ROW_W-1:0]  fe_row_r, fe_row_nxt;
  logic [dmt_pkg::COL_W-1:0]  fe_col_r, fe_col_nxt;
  logic [dmt_pkg::ROW_W-1:0]  bk_row_r, bk_row_nxt;
  logic [dmt_pkg::COL_W-1:0]  bk_col_r, bk_col_nxt;
  logic                       bdone_r, bdone_nxt;
  logic                       cell_r, cell_nxt;
  logic [dmt_pkg::DIST_W-1:0] prev_r, prev_nxt;
  logic                       out_valid_r, out_valid_nxt;
  dmt_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                       accept;
  logic                       out_free;
  logic                       fe_last;
  logic [dmt_pkg::DIST_W-1:0] fwd_val;
  logic [dmt_pkg::DIST_W-1:0] bwd_val;

  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign fe_last   = (fe_row_r == geom.last_row) && (fe_col_r == geom.last_col);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // forward pass: top comes from memory, left is the value written just before
  always_comb begin
    fwd_val = dmt_pkg::DIST_SAT;
    if (ld_row_r != '0) begin
      fwd_val = dmt_pkg::dmin(fwd_val, dmt_pkg::sat_inc(mem_rdata_a));
    end
    if (ld_col_r != '0) begin
      fwd_val = dmt_pkg::dmin(fwd_val, dmt_pkg::sat_inc(prev_r));
    end
    if (!cell_r) begin
      fwd_val = '0;
    end
  end

  // backward pass: rdata_a is the cell, rdata_b the one below, prev_r the right
  always_comb begin
    bwd_val = mem_rdata_a;
    if (mem_rdata_a != '0) begin
      if (bk_row_r != geom.last_row) begin
        bwd_val = dmt_pkg::dmin(bwd_val, dmt_pkg::sat_inc(mem_rdata_b));
      end
      if (bk_col_r != geom.last_col) begin
        bwd_val = dmt_pkg::dmin(bwd_val, dmt_pkg::sat_inc(prev_r));
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == dmt_pkg::CMD_LOAD) begin
            state_nxt = dmt_pkg::ST_FWR;
          end else if (bdone_r) begin
            state_nxt = dmt_pkg::ST_FDATA;
          end
        end
      end
      dmt_pkg::ST_FWR: begin
        if (ld_row_r == geom.last_row && ld_col_r == geom.last_col) begin
          state_nxt = dmt_pkg::ST_BRD;
        end else begin
          state_nxt = dmt_pkg::ST_IDLE;
        end
      end
      dmt_pkg::ST_BRD: state_nxt = dmt_pkg::ST_BWR;
      dmt_pkg::ST_BWR: begin
        if (bk_row_r == '0 && bk_col_r == '0) begin
          state_nxt = dmt_pkg::ST_IDLE;
        end else begin
          state_nxt = dmt_pkg::ST_BRD;
        end
      end
      dmt_pkg::ST_FDATA: begin
        if (out_free) begin
          state_nxt = dmt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state_r != dmt_pkg::ST_IDLE);
    mem_we      = 1'b0;
    mem_waddr   = dmt_pkg::cell_addr(ld_row_r, ld_col_r);
    mem_wdata   = fwd_val;
    mem_raddr_b = dmt_pkg::cell_addr(fe_row_r, fe_col_r);
    if (ld_row_r == '0) begin
      mem_raddr_a = dmt_pkg::cell_addr(ld_row_r, ld_col_r);
    end else begin
      mem_raddr_a = dmt_pkg::cell_addr(ld_row_r - 1'b1, ld_col_r);
    end
    case (state_r)
      dmt_pkg::ST_FWR: mem_we = 1'b1;
      dmt_pkg::ST_BRD: begin
        mem_raddr_a = dmt_pkg::cell_addr(bk_row_r, bk_col_r);
        if (bk_row_r == geom.last_row) begin
          mem_raddr_b = dmt_pkg::cell_addr(bk_row_r, bk_col_r);
        end else begin
          mem_raddr_b = dmt_pkg::cell_addr(bk_row_r + 1'b1, bk_col_r);
        end
      end
      dmt_pkg::ST_BWR: begin
        mem_we    = 1'b1;
        mem_waddr = dmt_pkg::cell_addr(bk_row_r, bk_col_r);
        mem_wdata = bwd_val;
      end
      default: ;
    endcase
  end

  always_comb begin
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    fe_row_nxt    = fe_row_r;
    fe_col_nxt    = fe_col_r;
    bk_row_nxt    = bk_row_r;
    bk_col_nxt    = bk_col_r;
    bdone_nxt     = bdone_r;
    cell_nxt      = cell_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      dmt_pkg::ST_IDLE: begin
        if (accept && in_data.cmd == dmt_pkg::CMD_LOAD) begin
          cell_nxt = in_data.cell_value;
          // a load after a finished image starts a new one
          if (bdone_r) begin
            ld_row_nxt = '0;
            ld_col_nxt = '0;
            fe_row_nxt = '0;
            fe_col_nxt = '0;
            bdone_nxt  = 1'b0;
          end
        end
      end
      dmt_pkg::ST_FWR: begin
        prev_nxt = fwd_val;
        if (ld_col_r == geom.last_col) begin
          ld_col_nxt = '0;
          if (ld_row_r == geom.last_row) begin
            ld_row_nxt = '0;
            bk_row_nxt = geom.last_row;
            bk_col_nxt = geom.last_col;
          end else begin
            ld_row_nxt = ld_row_r + 1'b1;
          end
        end else begin
          ld_col_nxt = ld_col_r + 1'b1;
        end
      end
      dmt_pkg::ST_BWR: begin
        prev_nxt = bwd_val;
        if (bk_col_r == '0) begin
          bk_col_nxt = geom.last_col;
          if (bk_row_r == '0) begin
            bdone_nxt  = 1'b1;
            fe_row_nxt = '0;
            fe_col_nxt = '0;
          end else begin
            bk_row_nxt = bk_row_r - 1'b1;
          end
        end else begin
          bk_col_nxt = bk_col_r - 1'b1;
        end
      end
      dmt_pkg::ST_FDATA: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.distance  = mem_rdata_b;
          out_data_nxt.row_index = dmt_pkg::IDX_W'(fe_row_r);
          out_data_nxt.col_index = dmt_pkg::IDX_W'(fe_col_r);
          out_data_nxt.last      = fe_last;
          if (fe_col_r == geom.last_col) begin
            fe_col_nxt = '0;
            fe_row_nxt = fe_last ? '0 : fe_row_r + 1'b1;
          end else begin
            fe_col_nxt = fe_col_r + 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (geom.restart) begin
      ld_row_nxt = '0;
      ld_col_nxt = '0;
      fe_row_nxt = '0;
      fe_col_nxt = '0;
      bdone_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmt_pkg::ST_IDLE;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      fe_row_r    <= '0;
      fe_col_r    <= '0;
      bk_row_r    <= '0;
      bk_col_r    <= '0;
      bdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      fe_row_r    <= fe_row_nxt;
      fe_col_r    <= fe_col_nxt;
      bk_row_r    <= bk_row_nxt;
      bk_col_r    <= bk_col_nxt;
      bdone_r     <= bdone_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[design/manhattan_distance_transform.sv]
// Manhattan distance transform over a binary image of up to 64 x 64 cells.
// Input channel (in_valid / in_stall / in_data): cmd LOAD writes the next
// cell in raster order, cmd FETCH reads the next distance out. Output
// channel (out_valid / out_stall / out_data) gives one transaction per
// served fetch: distance, row, column and a last mark on the final cell.
// Image size comes from row_count and col_count on the APB port; any write
// restarts the image. Write them only while the block is idle.
// Sequence: a load first reads the top neighbor from the distance RAM,
// then does the forward-pass write. After the last load the backward pass
// sweeps the image in reverse, with a read state and a write state per
// cell, and in_stall stays high until the sweep is done. A fetch reads
// the distance RAM, then loads the output register.
// A fetch before the image is complete is taken and dropped.
// When out_stall holds a result, the next transaction is still accepted;
// a following fetch waits until the output register frees up.
// Reset clears positions and status only; the RAM needs no clearing pass.
module manhattan_distance_transform (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dmt_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dmt_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dmt_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [dmt_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [dmt_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  dmt_pkg::geom_t             geom;
  logic                       mem_we;
  logic [dmt_pkg::ADDR_W-1:0] mem_waddr;
  logic [dmt_pkg::DIST_W-1:0] mem_wdata;
  logic [dmt_pkg::ADDR_W-1:0] mem_raddr_a;
  logic [dmt_pkg::DIST_W-1:0] mem_rdata_a;
  logic [dmt_pkg::ADDR_W-1:0] mem_raddr_b;
  logic [dmt_pkg::DIST_W-1:0] mem_rdata_b;

  dmt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .geom        (geom)
  );

  dmt_ram u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .rdata_a (mem_rdata_a),
    .raddr_b (mem_raddr_b),
    .rdata_b (mem_rdata_b)
  );

  dmt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .geom        (geom),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_rdata_a (mem_rdata_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_b (mem_rdata_b)
  );

endmodule

[design/dmt_checker.sv]
module dmt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dmt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dmt_pkg::out_item_t out_data
);

  // output holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // an accepted load leaves the sequencer busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.cmd == dmt_pkg::CMD_LOAD) |=> in_stall)
    else $error("load accepted without busy cycle");

  // a new result only appears after an accepted fetch, via the RAM read and the output register
  a_result_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && (in_data.cmd == dmt_pkg::CMD_FETCH), 2))
    else $error("result without fetch");

endmodule

bind manhattan_distance_transform dmt_checker u_dmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  // Tracks the image the way the block should: forward pass per load,
  // backward sweep when the last cell lands, raster readout per fetch.
  class dt_scoreboard;
    logic [dmt_pkg::DIST_W-1:0] dist_mem [dmt_pkg::DEPTH];
    logic [dmt_pkg::CFG_W-1:0]  row_reg;
    logic [dmt_pkg::CFG_W-1:0]  col_reg;
    int unsigned                load_pos;
    int unsigned                fetch_pos;
    bit                         swept;
    dmt_pkg::out_item_t         readout_q[$];
    int unsigned                mismatches;

    function new();
      row_reg    = dmt_pkg::ROW_COUNT_RST;
      col_reg    = dmt_pkg::COL_COUNT_RST;
      load_pos   = 0;
      fetch_pos  = 0;
      swept      = 0;
      mismatches = 0;
    endfunction

    function int unsigned rows_used();
      if (row_reg == 0) return 1;
      if (row_reg > dmt_pkg::MAX_ROWS) return dmt_pkg::MAX_ROWS;
      return row_reg;
    endfunction

    function int unsigned cols_used();
      if (col_reg == 0) return 1;
      if (col_reg > dmt_pkg::MAX_COLS) return dmt_pkg::MAX_COLS;
      return col_reg;
    endfunction

    function logic [dmt_pkg::DIST_W-1:0] step_up(logic [dmt_pkg::DIST_W-1:0] v);
      logic [dmt_pkg::DIST_W:0] s;
      s = {1'b0, v} + 1'b1;
      return s[dmt_pkg::DIST_W] ? dmt_pkg::DIST_SAT : s[dmt_pkg::DIST_W-1:0];
    endfunction

    function void configure(logic idx, logic [dmt_pkg::CFG_W-1:0] val);
      if (idx == dmt_pkg::REG_ROW_COUNT) row_reg = val;
      else col_reg = val;
      load_pos  = 0;
      fetch_pos = 0;
      swept     = 0;
    endfunction

    function void backward_sweep(int rows, int cols);
      logic [dmt_pkg::DIST_W-1:0] v;
      logic [dmt_pkg::DIST_W-1:0] t;
      for (int r = rows - 1; r >= 0; r--) begin
        for (int c = cols - 1; c >= 0; c--) begin
          v = dist_mem[r*dmt_pkg::MAX_COLS + c];
          if (v != 0) begin
            if (r + 1 < rows) begin
              t = step_up(dist_mem[(r+1)*dmt_pkg::MAX_COLS + c]);
              if (t < v) v = t;
            end
            if (c + 1 < cols) begin
              t = step_up(dist_mem[r*dmt_pkg::MAX_COLS + c + 1]);
              if (t < v) v = t;
            end
            dist_mem[r*dmt_pkg::MAX_COLS + c] = v;
          end
        end
      end
    endfunction

    function void note_input(dmt_pkg::in_item_t it);
      int unsigned                rows, cols, total, r, c;
      logic [dmt_pkg::DIST_W-1:0] v;
      logic [dmt_pkg::DIST_W-1:0] t;
      dmt_pkg::out_item_t         want;
      rows  = rows_used();
      cols  = cols_used();
      total = rows * cols;
      if (it.cmd == dmt_pkg::CMD_LOAD) begin
        // a load after a finished image starts a fresh one
        if (swept || load_pos >= total) begin
          load_pos  = 0;
          fetch_pos = 0;
          swept     = 0;
        end
        r = load_pos / cols;
        c = load_pos % cols;
        if (it.cell_value == 1'b0) begin
          v = '0;
        end else begin
          v = dmt_pkg::DIST_SAT;
          if (r > 0) begin
            t = step_up(dist_mem[(r-1)*dmt_pkg::MAX_COLS + c]);
            if (t < v) v = t;
          end
          if (c > 0) begin
            t = step_up(dist_mem[r*dmt_pkg::MAX_COLS + c - 1]);
            if (t < v) v = t;
          end
        end
        dist_mem[r*dmt_pkg::MAX_COLS + c] = v;
        load_pos++;
        if (load_pos >= total) begin
          backward_sweep(rows, cols);
          swept     = 1;
          fetch_pos = 0;
        end
      end else if (swept) begin
        if (fetch_pos >= total) fetch_pos = 0;
        r = fetch_pos / cols;
        c = fetch_pos % cols;
        want.distance  = dist_mem[r*dmt_pkg::MAX_COLS + c];
        want.row_index = dmt_pkg::IDX_W'(r);
        want.col_index = dmt_pkg::IDX_W'(c);
        want.last      = (fetch_pos + 1 == total);
        fetch_pos      = want.last ? 0 : fetch_pos + 1;
        readout_q.push_back(want);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(dmt_pkg::out_item_t got);
      dmt_pkg::out_item_t want;
      if (readout_q.size() == 0) begin
        flag($sformatf("unexpected readout: dist=%0d row=%0d col=%0d last=%0b",
                       got.distance, got.row_index, got.col_index, got.last));
        return;
      end
      want = readout_q.pop_front();
      if (got.distance !== want.distance || got.row_index !== want.row_index ||
          got.col_index !== want.col_index || got.last !== want.last)
        flag($sformatf({"readout mismatch: expected dist=%0d row=%0d col=%0d last=%0b,",
                        " got dist=%0d row=%0d col=%0d last=%0b"},
                       want.distance, want.row_index, want.col_index, want.last,
                       got.distance, got.row_index, got.col_index, got.last));
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  dmt_pkg::in_item_t            in_data;
  logic                         out_valid;
  logic                         out_stall;
  dmt_pkg::out_item_t           out_data;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [dmt_pkg::APB_AW-1:0]   cfg_paddr;
  logic [dmt_pkg::APB_DW-1:0]   cfg_pwdata;
  logic [dmt_pkg::APB_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  dt_scoreboard sb;
  bit           in_idle_on;
  bit           out_idle_on;
  int unsigned  n_sent;

  manhattan_distance_transform uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= out_idle_on && ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_item(input dmt_pkg::in_item_t it);
    @(negedge clk);
    while (in_idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      in_data  <= dmt_pkg::in_item_t'(2'($urandom));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    n_sent++;
  endtask

  task automatic load_cell(input logic v);
    send_item(dmt_pkg::in_item_t'{cmd: dmt_pkg::CMD_LOAD, cell_value: v});
  endtask

  task automatic fetch_cell();
    send_item(dmt_pkg::in_item_t'{cmd: dmt_pkg::CMD_FETCH, cell_value: 1'($urandom)});
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.readout_q.size() != 0) @(posedge clk);
  endtask

  // no results pending and any backward sweep finished
  task automatic hold_until_idle();
    drain_results();
    repeat (2 * sb.rows_used() * sb.cols_used() + 10) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [dmt_pkg::CFG_W-1:0] val);
    logic [dmt_pkg::APB_DW-1:0] wd;
    wd = $urandom;
    wd[dmt_pkg::CFG_W-1:0] = val;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wd;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.configure(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic run_image(input int unsigned zero_pct, input bit allow_short);
    int unsigned total, n_load, n_fetch;
    total  = sb.rows_used() * sb.cols_used();
    n_load = total;
    if (allow_short && $urandom_range(0, 9) == 0) n_load = $urandom_range(1, total);
    for (int k = 0; k < n_load; k++) begin
      // stray fetch while loading: dropped unless the previous image is still complete
      if ($urandom_range(0, 19) == 0) fetch_cell();
      load_cell($urandom_range(0, 99) >= zero_pct);
    end
    case ($urandom_range(0, 5))
      0: begin
        n_fetch = $urandom_range(1, total);
      end
      1: begin
        n_fetch = total + $urandom_range(1, total);
      end
      default: begin
        n_fetch = total;
      end
    endcase
    if (!allow_short) n_fetch = total;
    repeat (n_fetch) fetch_cell();
    if ($urandom_range(0, 3) == 0) drain_results();
  endtask

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 100;
      2: return 5;
      3: return 30;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  initial begin
    int unsigned phase;
    bit          quiet;
    int unsigned lo;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    n_sent      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fetches before any image is complete give nothing
    fetch_cell();
    fetch_cell();
    hold_until_idle();

    // 2 x 3 image, readout wraps past the last cell
    apb_write(dmt_pkg::REG_ROW_COUNT, dmt_pkg::CFG_W'(2));
    apb_write(dmt_pkg::REG_COL_COUNT, dmt_pkg::CFG_W'(3));
    load_cell(1'b1);
    load_cell(1'b0);
    load_cell(1'b1);
    load_cell(1'b1);
    load_cell(1'b1);
    load_cell(1'b1);
    repeat (7) fetch_cell();
    drain_results();
    hold_until_idle();

    // zero sizes act as 1; a lone nonzero cell stays at the sentinel
    apb_write(dmt_pkg::REG_ROW_COUNT, dmt_pkg::CFG_W'(0));
    apb_write(dmt_pkg::REG_COL_COUNT, dmt_pkg::CFG_W'(0));
    load_cell(1'b1);
    fetch_cell();
    fetch_cell();
    load_cell(1'b0);
    fetch_cell();
    hold_until_idle();

    // full-height image; out of range row count clamps
    apb_write(dmt_pkg::REG_ROW_COUNT, dmt_pkg::CFG_W'(127));
    apb_write(dmt_pkg::REG_COL_COUNT, dmt_pkg::CFG_W'(2));
    run_image(2, 1'b0);
    hold_until_idle();

    phase = 0;
    while (n_sent < 2000) begin
      hold_until_idle();
      quiet       = (phase % 4 == 3);
      in_idle_on  = !quiet;
      out_idle_on = !quiet;
      lo          = quiet ? 4 : 0;
      case (quiet ? 2 : $urandom_range(0, 9))
        0: begin
          apb_write(dmt_pkg::REG_ROW_COUNT, dmt_pkg::CFG_W'($urandom_range(64, 127)));
          apb_write(dmt_pkg::REG_COL_COUNT, dmt_pkg::CFG_W'($urandom_range(0, 3)));
        end
        1: begin
          apb_write(dmt_pkg::REG_COL_COUNT, dmt_pkg::CFG_W'($urandom_range(64, 127)));
          apb_write(dmt_pkg::REG_ROW_COUNT, dmt_pkg::CFG_W'($urandom_range(0, 3)));
        end
        default: begin
          case (quiet ? 2 : $urandom_range(0, 2))
            0: begin
              apb_write(dmt_pkg::REG_ROW_COUNT, dmt_pkg::CFG_W'($urandom_range(0, 8)));
            end
            1: begin
              apb_write(dmt_pkg::REG_COL_COUNT, dmt_pkg::CFG_W'($urandom_range(0, 8)));
            end
            default: begin
              apb_write(dmt_pkg::REG_ROW_COUNT, dmt_pkg::CFG_W'($urandom_range(lo, 8)));
              apb_write(dmt_pkg::REG_COL_COUNT, dmt_pkg::CFG_W'($urandom_range(lo, 8)));
            end
          endcase
        end
      endcase
      repeat (quiet ? 3 : $urandom_range(1, 3)) run_image(pick_density(), 1'b1);
      phase++;
    end

    drain_results();
    repeat (2 * sb.rows_used() * sb.cols_used() + 20) @(posedge clk);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
